// File: rtl/msbt_pkg.sv
// ----------------------------------------------------------------------------
// msbt_pkg: shared types and constants for the largest-square search block
// Sizes, payload types, controller/datapath command and status structs, and
// small helper functions used by more than one file.
// ----------------------------------------------------------------------------
package msbt_pkg;

	// sizing
	localparam int MAX_DIM   = 64;
	localparam int CELL_BITS = 16;

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CRD_W  = IDX_W + 1;
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int TOT_W  = 2 * DIM_W;
	localparam int DIAG_W = $clog2(2 * MAX_DIM);
	localparam int DSUM_W = DIM_W + 1;
	localparam int PROD_W = IDX_W + DIM_W;
	localparam int SUM_W  = CELL_BITS + ADDR_W;

	// fixed field widths
	localparam int CFG_DIM_W  = 7;
	localparam int LIMIT_W    = 29;
	localparam int CFG_DATA_W = 29;
	localparam int CFG_IDX_W  = 2;
	localparam int SIDE_W     = 7;
	localparam int CMP_W      = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

	localparam int SIDE_TOP = (2 ** SIDE_W) - 1;
	localparam int MAX_SIDE = (MAX_DIM < SIDE_TOP) ? MAX_DIM : SIDE_TOP;

	typedef logic [CRD_W-1:0]      crd_t;
	typedef logic [DIM_W-1:0]      dim_t;
	typedef logic [ADDR_W-1:0]     addr_t;
	typedef logic [CNT_W-1:0]      cnt_t;
	typedef logic [TOT_W-1:0]      tot_t;
	typedef logic [DIAG_W-1:0]     diag_t;
	typedef logic [DSUM_W-1:0]     dsum_t;
	typedef logic [PROD_W-1:0]     prod_t;
	typedef logic [SUM_W-1:0]      sum_t;
	typedef logic [CMP_W-1:0]      cmp_t;
	typedef logic [CELL_BITS-1:0]  cell_t;
	typedef logic [SIDE_W-1:0]     side_t;
	typedef logic [LIMIT_W-1:0]    limit_t;
	typedef logic [CFG_DIM_W-1:0]  cfg_dim_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS  = 2'd0,
		REG_COLS  = 2'd1,
		REG_LIMIT = 2'd2
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic load_cell;
		logic search_init;
		logic diag_init;
		logic diag_next;
		logic note;
		logic walk_begin;
		logic walk_shrink;
		logic walk_step;
		logic res_load;
	} msbt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic load_last;
		logic below;
		logic upper_out;
		logic window_empty;
		logic walk_last;
		logic diag_last;
	} msbt_stat_t;

	// zero counts as one, anything above the array size counts as the array size
	function automatic dim_t eff_dim(input cfg_dim_t v);
		dim_t r;
		if (v == '0) begin
			r = dim_t'(1);
		end else if (int'(v) > MAX_DIM) begin
			r = dim_t'(MAX_DIM);
		end else begin
			r = dim_t'(v);
		end
		return r;
	endfunction

	// clamp a side to the output field
	function automatic side_t sat_side(input crd_t v);
		side_t r;
		if (int'(v) > SIDE_TOP) begin
			r = side_t'(SIDE_TOP);
		end else begin
			r = side_t'(v);
		end
		return r;
	endfunction

endpackage

// File: rtl/msbt_cell_if.sv
// ----------------------------------------------------------------------------
// msbt_cell_if: matrix cell channel
// Valid/ready channel carrying one matrix cell per request.
// ----------------------------------------------------------------------------
interface msbt_cell_if;
	logic                 valid;
	logic                 ready;
	msbt_pkg::cell_t      cell_value;

	modport source (output valid, output cell_value, input ready);
	modport sink (input valid, input cell_value, output ready);
endinterface

// File: rtl/msbt_side_if.sv
// ----------------------------------------------------------------------------
// msbt_side_if: result channel
// Valid/ready channel carrying the best square side of one matrix.
// ----------------------------------------------------------------------------
interface msbt_side_if;
	logic                 valid;
	logic                 ready;
	msbt_pkg::side_t      best_side;

	modport source (output valid, output best_side, input ready);
	modport sink (input valid, input best_side, output ready);
endinterface

// File: rtl/msbt_ctrl.sv
// ----------------------------------------------------------------------------
// msbt_ctrl: search sequencer
// Loads cells, then steps the two-pointer window along every diagonal and
// hands the best side to the output register.
// ----------------------------------------------------------------------------
module msbt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cell_valid,
	output logic                 cell_ready,
	output logic                 side_valid,
	input  logic                 side_ready,
	input  msbt_pkg::msbt_stat_t stat,
	output msbt_pkg::msbt_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_DIAG_START,
		ST_DECIDE,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   side_valid_q;
	logic   diag_done;
	logic   res_free;

	// diagonal ends when the upper corner leaves the matrix, or an empty window
	// is already at the limit
	assign diag_done = stat.upper_out || (!stat.below && stat.window_empty);
	assign res_free  = !side_valid_q || side_ready;

	assign cell_ready = (state_q == ST_LOAD);
	assign side_valid = side_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_LOAD: begin
				cmd.load_cell   = cell_valid;
				cmd.search_init = cell_valid && stat.load_last;
			end
			ST_DIAG_START: begin
				cmd.diag_init = 1'b1;
			end
			ST_DECIDE: begin
				cmd.note = stat.below;
				if (diag_done) begin
					cmd.diag_next = !stat.diag_last;
				end else begin
					cmd.walk_begin  = 1'b1;
					cmd.walk_shrink = !stat.below;
				end
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
			end
			ST_FINISH: begin
				cmd.res_load = res_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOAD;
			side_valid_q <= 1'b0;
		end else begin
			// new result takes the output register, else a taken one leaves it
			if ((state_q == ST_FINISH) && res_free) begin
				side_valid_q <= 1'b1;
			end else if (side_valid_q && side_ready) begin
				side_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (cell_valid && stat.load_last) begin
						state_q <= ST_DIAG_START;
					end
				end
				ST_DIAG_START: begin
					state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (diag_done) begin
						state_q <= stat.diag_last ? ST_FINISH : ST_DIAG_START;
					end else begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (stat.walk_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DECIDE;
				end
				ST_FINISH: begin
					if (res_free) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

endmodule

// File: rtl/msbt_datapath.sv
// ----------------------------------------------------------------------------
// msbt_datapath: matrix store, window pointers and window sum
// Holds configuration, the cell memory, the L-strip walker that reads one
// cell per cycle, the running window sum and the best side found.
// ----------------------------------------------------------------------------
module msbt_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  msbt_pkg::cfg_idx_t   cfg_index,
	input  msbt_pkg::cfg_data_t  cfg_data,
	input  msbt_pkg::cell_t      cell_value,
	input  msbt_pkg::msbt_cmd_t  cmd,
	output msbt_pkg::msbt_stat_t stat,
	output msbt_pkg::side_t      best_side
);

	// configuration
	msbt_pkg::cfg_dim_t rows_q;
	msbt_pkg::cfg_dim_t cols_q;
	msbt_pkg::limit_t   limit_q;

	// load and store
	msbt_pkg::cnt_t  load_cnt_q;
	msbt_pkg::cell_t mem [msbt_pkg::DEPTH];
	msbt_pkg::cell_t rd_data_s1;
	logic            acc_valid_s1;
	logic            acc_sub_s1;

	// window and walker
	msbt_pkg::sum_t  sum_q;
	msbt_pkg::crd_t  ur_q, uc_q, lr_q, lc_q;
	msbt_pkg::crd_t  wr_q, wc_q;
	logic            shrink_q;
	msbt_pkg::diag_t diag_q;
	msbt_pkg::crd_t  best_q;
	msbt_pkg::side_t res_q;

	msbt_pkg::dim_t  nr, nc;
	msbt_pkg::tot_t  total, cnt_inc;
	logic            store_en;
	msbt_pkg::crd_t  side_now, uc_inc;
	msbt_pkg::prod_t prod;
	msbt_pkg::addr_t rd_addr;
	msbt_pkg::dsum_t diag_x, nr_x, nc_x;
	logic            in_bottom;
	msbt_pkg::crd_t  start_r, start_c;

	assign nr = msbt_pkg::eff_dim(rows_q);
	assign nc = msbt_pkg::eff_dim(cols_q);

	assign total    = msbt_pkg::tot_t'(nr) * msbt_pkg::tot_t'(nc);
	assign cnt_inc  = msbt_pkg::tot_t'(load_cnt_q) + msbt_pkg::tot_t'(1);
	assign store_en = cmd.load_cell && (msbt_pkg::tot_t'(load_cnt_q) < total);

	assign side_now = lr_q - ur_q;
	assign uc_inc   = uc_q + msbt_pkg::crd_t'(1);

	// cell address of the walker, row-major with the current column count
	assign prod    = msbt_pkg::prod_t'(wr_q[msbt_pkg::IDX_W-1:0]) * msbt_pkg::prod_t'(nc)
	                 + msbt_pkg::prod_t'(wc_q[msbt_pkg::IDX_W-1:0]);
	assign rd_addr = prod[msbt_pkg::ADDR_W-1:0];

	// diagonal start: bottom row first, then last column from the top row down
	assign diag_x    = msbt_pkg::dsum_t'(diag_q);
	assign nr_x      = msbt_pkg::dsum_t'(nr);
	assign nc_x      = msbt_pkg::dsum_t'(nc);
	assign in_bottom = diag_x < nc_x;
	assign start_r   = in_bottom ? msbt_pkg::crd_t'(nr_x - msbt_pkg::dsum_t'(1))
	                             : msbt_pkg::crd_t'(diag_x - nc_x);
	assign start_c   = in_bottom ? msbt_pkg::crd_t'(diag_x)
	                             : msbt_pkg::crd_t'(nc_x - msbt_pkg::dsum_t'(1));

	always_comb begin
		stat.load_last    = cnt_inc >= total;
		stat.below        = msbt_pkg::cmp_t'(sum_q) < msbt_pkg::cmp_t'(limit_q);
		stat.upper_out    = ur_q[msbt_pkg::CRD_W-1] | uc_q[msbt_pkg::CRD_W-1];
		stat.window_empty = (lr_q == ur_q);
		stat.walk_last    = shrink_q ? ((wr_q == lr_q) && (wc_q == uc_inc))
		                             : ((wr_q == ur_q) && (wc_q == lc_q));
		stat.diag_last    = diag_x == (nr_x + nc_x - msbt_pkg::dsum_t'(2));
	end

	assign best_side = res_q;

	// configuration registers and load counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= msbt_pkg::cfg_dim_t'(1);
			cols_q     <= msbt_pkg::cfg_dim_t'(1);
			limit_q    <= '0;
			load_cnt_q <= '0;
			acc_valid_s1 <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					msbt_pkg::REG_ROWS:  rows_q  <= cfg_data[msbt_pkg::CFG_DIM_W-1:0];
					msbt_pkg::REG_COLS:  cols_q  <= cfg_data[msbt_pkg::CFG_DIM_W-1:0];
					msbt_pkg::REG_LIMIT: limit_q <= cfg_data[msbt_pkg::LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load_cell) begin
				load_cnt_q <= stat.load_last ? '0 : msbt_pkg::cnt_t'(cnt_inc);
			end
			acc_valid_s1 <= cmd.walk_step;
		end
	end

	// cell memory
	always_ff @(posedge clk) begin
		if (store_en) begin
			mem[load_cnt_q[msbt_pkg::ADDR_W-1:0]] <= cell_value;
		end
		rd_data_s1 <= mem[rd_addr];
	end

	// window sum, pointers, walker, best side
	always_ff @(posedge clk) begin
		acc_sub_s1 <= shrink_q;

		if (cmd.diag_init) begin
			sum_q <= '0;
		end else if (acc_valid_s1) begin
			sum_q <= acc_sub_s1 ? sum_q - msbt_pkg::sum_t'(rd_data_s1)
			                    : sum_q + msbt_pkg::sum_t'(rd_data_s1);
		end

		if (cmd.diag_init) begin
			ur_q <= start_r;
			lr_q <= start_r;
			uc_q <= start_c;
			lc_q <= start_c;
		end else if (cmd.walk_step && stat.walk_last) begin
			if (shrink_q) begin
				lr_q <= lr_q - msbt_pkg::crd_t'(1);
				lc_q <= lc_q - msbt_pkg::crd_t'(1);
			end else begin
				ur_q <= ur_q - msbt_pkg::crd_t'(1);
				uc_q <= uc_q - msbt_pkg::crd_t'(1);
			end
		end

		// grow strip: up the new left column, then right along the new top row
		// shrink strip: down the old right column, then left along the old bottom row
		if (cmd.walk_begin) begin
			shrink_q <= cmd.walk_shrink;
			if (cmd.walk_shrink) begin
				wr_q <= ur_q + msbt_pkg::crd_t'(1);
				wc_q <= lc_q;
			end else begin
				wr_q <= lr_q;
				wc_q <= uc_q;
			end
		end else if (cmd.walk_step) begin
			if (shrink_q) begin
				if (wr_q != lr_q) begin
					wr_q <= wr_q + msbt_pkg::crd_t'(1);
				end else begin
					wc_q <= wc_q - msbt_pkg::crd_t'(1);
				end
			end else begin
				if (wr_q != ur_q) begin
					wr_q <= wr_q - msbt_pkg::crd_t'(1);
				end else begin
					wc_q <= wc_q + msbt_pkg::crd_t'(1);
				end
			end
		end

		if (cmd.search_init) begin
			diag_q <= '0;
		end else if (cmd.diag_next) begin
			diag_q <= diag_q + msbt_pkg::diag_t'(1);
		end

		if (cmd.search_init) begin
			best_q <= '0;
		end else if (cmd.note && (side_now > best_q)) begin
			best_q <= side_now;
		end

		if (cmd.res_load) begin
			res_q <= msbt_pkg::sat_side(best_q);
		end
	end

endmodule

// File: rtl/max_square_below_threshold_top.sv
// ----------------------------------------------------------------------------
// max_square_below_threshold_top: largest square submatrix with sum below limit
// Streams in a rows-by-cols matrix and returns the largest square side whose
// cell sum is strictly below the configured limit.
// ----------------------------------------------------------------------------
// Cells arrive row-major on cell_ch, one request per cycle while ready is high;
// the user sets rows, cols and limit via the write port only while the block
// is idle, not enforced by the block (0 counts as 1, above 64 as 64). When the
// matrix is taken the block drops ready and searches: it walks every diagonal
// (those starting on the bottom row, then those starting on the last column)
// with a two-pointer window, growing the upper-left corner by an L-shaped strip
// while the sum is below the limit and pulling in the lower-right corner
// otherwise. The single read port of the cell memory sets the pace: one cell is
// added or removed per cycle. A diagonal has a start step and a final decide
// step, and each window move a decide step, one walk step per strip cell and a
// drain step (2s+1 cells grow a side-s window, 2s-1 shrink it); the finish step
// hands the result to the output register, held while an earlier result still
// waits on side_ch. Loading runs at one cell per cycle and may continue while
// the result still waits on side_ch; a result of 0 means no square qualifies.
// ----------------------------------------------------------------------------
module max_square_below_threshold_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  msbt_pkg::cfg_idx_t  cfg_index,
	input  msbt_pkg::cfg_data_t cfg_data,
	msbt_cell_if.sink           cell_ch,
	msbt_side_if.source         side_ch
);

	// command and status between sequencer and datapath
	msbt_pkg::msbt_cmd_t  cmd;
	msbt_pkg::msbt_stat_t stat;

	// sequencer: owns the handshakes and the result valid flag
	msbt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cell_valid (cell_ch.valid),
		.cell_ready (cell_ch.ready),
		.side_valid (side_ch.valid),
		.side_ready (side_ch.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: config, cell memory, window arithmetic, result register
	msbt_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cell_value (cell_ch.cell_value),
		.cmd        (cmd),
		.stat       (stat),
		.best_side  (side_ch.best_side)
	);

endmodule

// File: rtl/msbt_checker.sv
// ----------------------------------------------------------------------------
// msbt_checker: port-level checks for the largest-square block
// Watches the cell and result channels from outside and is bound to the top.
// ----------------------------------------------------------------------------
module msbt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            cell_ready,
	input logic            side_valid,
	input logic            side_ready,
	input msbt_pkg::side_t best_side
);

	// a waiting result request holds
	a_side_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		side_valid && !side_ready |=> side_valid)
		else $error("result request dropped while stalled");

	a_side_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		side_valid && !side_ready |=> $stable(best_side))
		else $error("result changed while stalled");

	// side never exceeds the largest matrix
	a_side_range: assert property (@(posedge clk) disable iff (!arst_n)
		side_valid |-> (best_side <= msbt_pkg::side_t'(msbt_pkg::MAX_SIDE)))
		else $error("result side out of range");

	// a new result only follows a search, during which no cell is taken
	a_result_after_search: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(side_valid) |-> !$past(cell_ready))
		else $error("result appeared without a search");

endmodule

bind max_square_below_threshold_top msbt_checker u_msbt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cell_ready (cell_ch.ready),
	.side_valid (side_ch.valid),
	.side_ready (side_ch.ready),
	.best_side  (side_ch.best_side)
);
